// File: hw/rtl/qft_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qft_pkg
// Shared types and constants for the quoted field tokenizer.
// ----------------------------------------------------------------------------
package qft_pkg;

  // character codes
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_QUOTE = 8'h22;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;

  // configuration register indexes
  localparam logic [7:0] REG_EXTRA_DELIM_A = 8'd0;
  localparam logic [7:0] REG_EXTRA_DELIM_B = 8'd1;

  // configuration reset values
  localparam logic [7:0] EXTRA_DELIM_A_RESET = 8'd9;
  localparam logic [7:0] EXTRA_DELIM_B_RESET = 8'd10;

  // result kinds
  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // scanner state
  typedef enum logic [2:0] {
    MODE_START = 3'd0,
    MODE_UNQ   = 3'd1,
    MODE_QUO   = 3'd2,
    MODE_QSEEN = 3'd3,
    MODE_CR    = 3'd4
  } mode_t;

  // results caused by one byte: count, kind per slot, the one character
  typedef struct packed {
    logic [1:0] cnt;
    logic [2:0] kinds;
    logic [7:0] ch;
  } tok_entry_t;

endpackage

// File: hw/rtl/qft_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qft_front
// Classifies each input byte, updates the scanner state and builds the
// group of results that the byte causes.
// ----------------------------------------------------------------------------
module qft_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_index,
  input  logic [7:0]          cfg_data,
  input  logic                accept,
  input  logic [7:0]          in_byte,
  input  logic                record_last,
  output logic                push,
  output qft_pkg::tok_entry_t push_data
);

  logic [7:0]    extra_delim_a;
  logic [7:0]    extra_delim_b;
  qft_pkg::mode_t scan_mode, scan_mode_next;
  logic          field_open, field_open_next;
  logic          dropping, dropping_next;
  logic          is_delim;
  logic          is_quote;
  logic          is_break;
  qft_pkg::tok_entry_t entry;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      extra_delim_a <= qft_pkg::EXTRA_DELIM_A_RESET;
      extra_delim_b <= qft_pkg::EXTRA_DELIM_B_RESET;
    end else if (cfg_we) begin
      if (cfg_index == qft_pkg::REG_EXTRA_DELIM_A) begin
        extra_delim_a <= cfg_data;
      end else if (cfg_index == qft_pkg::REG_EXTRA_DELIM_B) begin
        extra_delim_b <= cfg_data;
      end
    end
  end

  // byte classes
  always_comb begin
    is_delim = (in_byte inside {qft_pkg::CHAR_COMMA, qft_pkg::CHAR_TAB})
            || ((extra_delim_a != qft_pkg::CHAR_NUL) && (in_byte == extra_delim_a))
            || ((extra_delim_b != qft_pkg::CHAR_NUL) && (in_byte == extra_delim_b));
    is_quote = (in_byte == qft_pkg::CHAR_QUOTE);
    is_break = is_delim || (in_byte inside {qft_pkg::CHAR_CR, qft_pkg::CHAR_LF});
  end

  // next state
  always_comb begin
    logic start_req;
    logic unq_req;
    start_req       = 1'b0;
    unq_req         = 1'b0;
    scan_mode_next  = scan_mode;
    field_open_next = field_open;
    dropping_next   = dropping;
    if (dropping) begin
      if (record_last) begin
        dropping_next   = 1'b0;
        scan_mode_next  = qft_pkg::MODE_START;
        field_open_next = 1'b0;
      end
    end else if (in_byte == qft_pkg::CHAR_NUL) begin
      field_open_next = 1'b0;
      scan_mode_next  = qft_pkg::MODE_START;
      dropping_next   = !record_last;
    end else begin
      case (scan_mode)
        qft_pkg::MODE_QSEEN: begin
          if (is_quote) begin
            scan_mode_next = qft_pkg::MODE_QUO;
          end else begin
            field_open_next = 1'b0;
            scan_mode_next  = qft_pkg::MODE_START;
            start_req       = !is_delim;
          end
        end
        qft_pkg::MODE_CR: begin
          scan_mode_next = qft_pkg::MODE_START;
          start_req      = (in_byte != qft_pkg::CHAR_LF);
        end
        qft_pkg::MODE_QUO: begin
          if (is_quote) begin
            scan_mode_next = qft_pkg::MODE_QSEEN;
          end
        end
        qft_pkg::MODE_UNQ: begin
          unq_req = 1'b1;
        end
        default: begin
          scan_mode_next  = qft_pkg::MODE_START;
          field_open_next = 1'b0;
          start_req       = 1'b1;
        end
      endcase
      // start of a new field
      if (start_req) begin
        field_open_next = 1'b1;
        if (is_quote) begin
          scan_mode_next = qft_pkg::MODE_QUO;
        end else begin
          unq_req = 1'b1;
        end
      end
      // byte inside an unquoted field
      if (unq_req) begin
        if (is_break) begin
          field_open_next = 1'b0;
          scan_mode_next  = (!is_delim && (in_byte == qft_pkg::CHAR_CR)) ?
                            qft_pkg::MODE_CR : qft_pkg::MODE_START;
        end else begin
          scan_mode_next = qft_pkg::MODE_UNQ;
        end
      end
      // record end closes everything
      if (record_last) begin
        field_open_next = 1'b0;
        scan_mode_next  = qft_pkg::MODE_START;
      end
    end
  end

  // results of this byte
  always_comb begin
    logic start_req;
    logic unq_req;
    logic opn;
    start_req   = 1'b0;
    unq_req     = 1'b0;
    opn         = field_open;
    entry       = '0;
    entry.ch    = in_byte;
    if (!dropping) begin
      if (in_byte == qft_pkg::CHAR_NUL) begin
        if (opn) begin
          entry.kinds[entry.cnt] = qft_pkg::KIND_END;
          entry.cnt              = entry.cnt + 2'd1;
        end
      end else begin
        case (scan_mode)
          qft_pkg::MODE_QSEEN: begin
            if (is_quote) begin
              entry.cnt = entry.cnt + 2'd1;
            end else begin
              entry.kinds[entry.cnt] = qft_pkg::KIND_END;
              entry.cnt              = entry.cnt + 2'd1;
              opn                    = 1'b0;
              start_req              = !is_delim;
            end
          end
          qft_pkg::MODE_CR: begin
            start_req = (in_byte != qft_pkg::CHAR_LF);
          end
          qft_pkg::MODE_QUO: begin
            if (!is_quote) begin
              entry.cnt = entry.cnt + 2'd1;
            end
          end
          qft_pkg::MODE_UNQ: begin
            unq_req = 1'b1;
          end
          default: begin
            opn       = 1'b0;
            start_req = 1'b1;
          end
        endcase
        // start of a new field
        if (start_req) begin
          opn = 1'b1;
          if (!is_quote) begin
            unq_req = 1'b1;
          end
        end
        // byte inside an unquoted field
        if (unq_req) begin
          if (is_break) begin
            entry.kinds[entry.cnt] = qft_pkg::KIND_END;
            opn                    = 1'b0;
          end
          entry.cnt = entry.cnt + 2'd1;
        end
        // record end closes an open field
        if (record_last && opn) begin
          entry.kinds[entry.cnt] = qft_pkg::KIND_END;
          entry.cnt              = entry.cnt + 2'd1;
        end
      end
    end
  end

  // scanner state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode  <= qft_pkg::MODE_START;
      field_open <= 1'b0;
      dropping   <= 1'b0;
    end else if (accept) begin
      scan_mode  <= scan_mode_next;
      field_open <= field_open_next;
      dropping   <= dropping_next;
    end
  end

  assign push      = accept && (entry.cnt != 2'd0);
  assign push_data = entry;

endmodule

// File: hw/rtl/qft_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qft_queue
// Small queue of result groups between the front and the back.
// ----------------------------------------------------------------------------
module qft_queue #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  qft_pkg::tok_entry_t push_data,
  output logic                full,
  input  logic                pop,
  output qft_pkg::tok_entry_t pop_data,
  output logic                empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  qft_pkg::tok_entry_t slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = slots[rd_ptr];

endmodule

// File: hw/rtl/qft_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qft_back
// Takes result groups from the queue and hands out one result per transfer.
// ----------------------------------------------------------------------------
module qft_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                empty,
  input  qft_pkg::tok_entry_t pop_data,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                kind,
  output logic [7:0]          out_char,
  output logic                run_last
);

  qft_pkg::tok_entry_t cur;
  logic                cur_valid;
  logic [1:0]          slot;
  logic                last_slot;
  logic                xfer;

  assign last_slot = (slot == (cur.cnt - 2'd1));
  assign xfer      = cur_valid && out_ready;
  assign pop       = !empty && (!cur_valid || (xfer && last_slot));

  // current group and slot
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= pop_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      slot      <= '0;
    end else if (pop) begin
      cur_valid <= 1'b1;
      slot      <= '0;
    end else if (xfer) begin
      if (last_slot) begin
        cur_valid <= 1'b0;
      end else begin
        slot <= slot + 2'd1;
      end
    end
  end

  // result fields
  assign out_valid = cur_valid;
  assign kind      = cur.kinds[slot];
  assign out_char  = (cur.kinds[slot] == qft_pkg::KIND_END) ? qft_pkg::CHAR_NUL : cur.ch;
  assign run_last  = last_slot;

endmodule

// File: hw/rtl/quoted_field_tokenizer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quoted_field_tokenizer_core
// Splits a byte stream of text records into field characters and field ends.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  : in_valid/in_ready with in_byte and record_last, one byte
//                 per transfer.
//   out channel : out_valid/out_ready with kind, out_char and run_last; each
//                 byte gives zero to three results, run_last marks its last.
//   cfg channel : cfg_valid/cfg_ready with cfg_index and cfg_data; index 0
//                 and 1 set the two extra delimiter bytes. Always ready.
//   A byte's result group is written into the queue at its input transfer,
//   then loaded into the back's current group, from which it is offered.
//   Throughput: one byte per cycle while the queue is not full; the output
//   side moves one result per cycle while out_ready is high, so bytes with
//   two or three results lag and a queue of DEPTH result groups absorbs it.
//   Reset: scanner state returns to field start, delimiters to 9 and 10,
//   queue and output empty.
//   When the receiver stalls, the current result holds and the queue fills;
//   in_ready drops only when the queue is full.
// ----------------------------------------------------------------------------
module quoted_field_tokenizer_core #(
  parameter int DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       record_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       kind,
  output logic [7:0] out_char,
  output logic       run_last
);

  logic                push;
  qft_pkg::tok_entry_t push_data;
  logic                full;
  logic                pop;
  qft_pkg::tok_entry_t pop_data;
  logic                empty;

  assign cfg_ready = 1'b1;
  assign in_ready  = !full;

  // byte classification and scanner
  qft_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .accept      (in_valid && in_ready),
    .in_byte     (in_byte),
    .record_last (record_last),
    .push        (push),
    .push_data   (push_data)
  );

  // decoupling queue
  qft_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  // result serializer
  qft_back u_back (
    .clk       (clk),
    .rst       (rst),
    .empty     (empty),
    .pop_data  (pop_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .kind      (kind),
    .out_char  (out_char),
    .run_last  (run_last)
  );

endmodule

// File: hw/rtl/qft_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qft_checker
// Port-level checks for the quoted field tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
module qft_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       kind,
  input logic [7:0] out_char,
  input logic       run_last
);

  // field end carries no character
  a_end_no_char: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == qft_pkg::KIND_END) |-> (out_char == qft_pkg::CHAR_NUL))
    else $error("field end with nonzero character");

  // a field character is never the record terminator
  a_char_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == qft_pkg::KIND_CHAR) |-> (out_char != qft_pkg::CHAR_NUL))
    else $error("field character is zero");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(out_char)
                                && $stable(run_last))
    else $error("stalled result changed");

  // input backpressure only while results are waiting
  a_bp_pending: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with no result pending");

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present after reset");

endmodule

bind quoted_field_tokenizer_core qft_checker u_qft_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .kind      (kind),
  .out_char  (out_char),
  .run_last  (run_last)
);
